[src/tsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, event codes and constants of the touch swipe classifier.
// ----------------------------------------------------------------------------
package tsc_pkg;

   localparam int unsigned POS_W   = 15;
   localparam int unsigned RAW_W   = 16;
   localparam int unsigned DELTA_W = 16;

   localparam logic [POS_W-1:0] THRESH_RESET = 15'd15;

   // Event codes on the result channel
   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_DOWN   = 3'd1,
      EV_UP     = 3'd2,
      EV_HELD   = 3'd3,
      EV_MOVE_X = 3'd4,
      EV_MOVE_Y = 3'd5
   } event_type;

   // One clamped touch sample
   typedef struct packed {
      logic             touched;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
   } sample_type;

   // A raw coordinate with its top bit set reads as zero
   function automatic logic [POS_W-1:0] clamp_raw(input logic [RAW_W-1:0] raw);
      logic [POS_W-1:0] res;
      res = raw[RAW_W-1] ? '0 : raw[POS_W-1:0];
      return res;
   endfunction

endpackage

[src/tsc_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc channels
// Valid/ready channel interfaces for touch samples and classified events.
// ----------------------------------------------------------------------------
interface tsc_req_if;
   logic        valid;
   logic        ready;
   logic        touched;
   logic [15:0] raw_x;
   logic [15:0] raw_y;

   modport source (output valid, touched, raw_x, raw_y, input ready);
   modport sink   (input valid, touched, raw_x, raw_y, output ready);
endinterface

interface tsc_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         event_res;
   logic [14:0]        pos_x;
   logic [14:0]        pos_y;
   logic signed [15:0] delta;

   modport source (output valid, event_res, pos_x, pos_y, delta, input ready);
   modport sink   (input valid, event_res, pos_x, pos_y, delta, output ready);
endinterface

[src/tsc_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_in_stage
// Input register: clamps raw coordinates and holds one sample for the
// classifier.
// ----------------------------------------------------------------------------
module tsc_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_touched,
   input  logic [15:0]           in_raw_x,
   input  logic [15:0]           in_raw_y,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tsc_pkg::sample_type   out_sample
);

   logic                 valid_ff;
   logic                 valid_in;
   tsc_pkg::sample_type  sample_ff;
   tsc_pkg::sample_type  sample_in;
   logic                 take;

   // Accept when empty or when the held item moves on this cycle
   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   // Clamp coordinates on the way in
   always_comb begin
      sample_in.touched = in_touched;
      sample_in.x       = tsc_pkg::clamp_raw(in_raw_x);
      sample_in.y       = tsc_pkg::clamp_raw(in_raw_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sample_ff <= sample_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sample = sample_ff;

endmodule

[src/tsc_classify.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_classify
// Gesture state and event classification, with the result register.
// ----------------------------------------------------------------------------
module tsc_classify (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [14:0]          threshold,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tsc_pkg::sample_type  in_sample,
   output logic                 res_valid,
   input  logic                 res_ready,
   output tsc_pkg::event_type   res_event,
   output logic [14:0]          res_pos_x,
   output logic [14:0]          res_pos_y,
   output logic signed [15:0]   res_delta
);

   logic                 was_touched_ff, was_touched_in;
   logic [14:0]          anchor_x_ff, anchor_x_in;
   logic [14:0]          anchor_y_ff, anchor_y_in;
   logic [14:0]          shown_x_ff, shown_x_in;
   logic [14:0]          shown_y_ff, shown_y_in;
   logic                 valid_ff, valid_in;
   tsc_pkg::event_type   event_ff, event_in;
   logic signed [15:0]   delta_ff, delta_in;

   logic                 advance;
   logic                 take;
   logic signed [15:0]   dx;
   logic signed [15:0]   dy_neg;
   logic [14:0]          abs_dx;
   logic [14:0]          abs_dy;
   logic                 moved;

   // Result register frees up when empty or taken downstream
   assign advance  = !valid_ff || res_ready;
   assign take     = in_valid && advance;
   assign in_ready = advance;

   // Displacement from the anchor; magnitudes fit in 15 bits
   assign dx     = $signed({1'b0, in_sample.x}) - $signed({1'b0, anchor_x_ff});
   assign dy_neg = $signed({1'b0, anchor_y_ff}) - $signed({1'b0, in_sample.y});
   assign abs_dx = dx[15] ? 15'(-dx) : dx[14:0];
   assign abs_dy = dy_neg[15] ? 15'(-dy_neg) : dy_neg[14:0];
   assign moved  = (abs_dx > threshold) || (abs_dy > threshold);

   // Classify the sample and work out the next state
   always_comb begin
      was_touched_in = was_touched_ff;
      anchor_x_in    = anchor_x_ff;
      anchor_y_in    = anchor_y_ff;
      shown_x_in     = shown_x_ff;
      shown_y_in     = shown_y_ff;
      event_in       = tsc_pkg::EV_NONE;
      delta_in       = '0;
      if (take) begin
         was_touched_in = in_sample.touched;
         if (in_sample.touched && !was_touched_ff) begin
            event_in    = tsc_pkg::EV_DOWN;
            shown_x_in  = in_sample.x;
            shown_y_in  = in_sample.y;
            anchor_x_in = in_sample.x;
            anchor_y_in = in_sample.y;
         end else if (!in_sample.touched && was_touched_ff) begin
            event_in   = tsc_pkg::EV_UP;
            shown_x_in = in_sample.x;
            shown_y_in = in_sample.y;
         end else if (in_sample.touched) begin
            event_in   = tsc_pkg::EV_HELD;
            shown_x_in = in_sample.x;
            shown_y_in = in_sample.y;
            if (moved) begin
               // Ties go to the Y axis
               if (abs_dx > abs_dy) begin
                  event_in = tsc_pkg::EV_MOVE_X;
                  delta_in = dx;
               end else begin
                  event_in = tsc_pkg::EV_MOVE_Y;
                  delta_in = dy_neg;
               end
               anchor_x_in = in_sample.x;
               anchor_y_in = in_sample.y;
            end
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (res_ready) begin
         valid_in = 1'b0;
      end
   end

   // Hold gesture state and the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         was_touched_ff <= 1'b0;
         anchor_x_ff    <= '0;
         anchor_y_ff    <= '0;
         shown_x_ff     <= '0;
         shown_y_ff     <= '0;
         valid_ff       <= 1'b0;
      end else begin
         was_touched_ff <= was_touched_in;
         anchor_x_ff    <= anchor_x_in;
         anchor_y_ff    <= anchor_y_in;
         shown_x_ff     <= shown_x_in;
         shown_y_ff     <= shown_y_in;
         valid_ff       <= valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (take) begin
         event_ff <= event_in;
         delta_ff <= delta_in;
      end
   end

   assign res_valid = valid_ff;
   assign res_event = event_ff;
   assign res_pos_x = shown_x_ff;
   assign res_pos_y = shown_y_ff;
   assign res_delta = delta_ff;

endmodule

[src/touch_swipe_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_swipe_classifier
// Turns touch-panel samples into press, release, held and swipe events.
// ----------------------------------------------------------------------------
// Every accepted sample yields exactly one event item, in order. An item
// passes an input register (coordinate clamp) and then the classifier with
// its result register. One item is taken every cycle while the result side
// keeps up; each stage stalls only when the stage after it is full.
// The move threshold (reset 15) is written through csr_we/csr_wdata and
// should only change while no item is in flight. Shown position and result
// register are both updated by the same transfer, so pos_x/pos_y belong to
// the item on the result channel.
module touch_swipe_classifier (
   input  logic        clock,
   input  logic        reset,
   tsc_req_if.sink     req,
   tsc_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [14:0] csr_wdata
);

   logic [14:0]          threshold_ff;
   logic [14:0]          threshold_in;
   logic                 fwd_valid;
   logic                 back_ready;
   tsc_pkg::sample_type  sample;
   tsc_pkg::event_type   ev;

   // Threshold register
   assign threshold_in = csr_we ? csr_wdata : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= tsc_pkg::THRESH_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   tsc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .in_touched (req.touched),
      .in_raw_x   (req.raw_x),
      .in_raw_y   (req.raw_y),
      .out_valid  (fwd_valid),
      .out_ready  (back_ready),
      .out_sample (sample)
   );

   tsc_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .threshold (threshold_ff),
      .in_valid  (fwd_valid),
      .in_ready  (back_ready),
      .in_sample (sample),
      .res_valid (rsp.valid),
      .res_ready (rsp.ready),
      .res_event (ev),
      .res_pos_x (rsp.pos_x),
      .res_pos_y (rsp.pos_y),
      .res_delta (rsp.delta)
   );

   assign rsp.event_res = 3'(ev);

endmodule

[tb/touch_swipe_classifier_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_swipe_classifier_tb
// Self-checking bench for the touch swipe classifier. Touch samples are sent
// on the request channel: first a short table of hand-picked samples, then
// random press / hold / release gestures mixed with noise. Each event item
// on the response channel is compared with a cycle-free model of the event
// logic. Both channels idle at random, the receiver stalls for a long
// stretch, and the move threshold is changed between phases while the
// block is empty.
// ----------------------------------------------------------------------------
module touch_swipe_classifier_tb;

   localparam int CLK_HALF    = 5;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 10;
   localparam int POS_MAX     = 32767;

   // One classified event as the response channel carries it
   typedef struct {
      tsc_pkg::event_type          ev;
      logic [tsc_pkg::POS_W-1:0]   x;
      logic [tsc_pkg::POS_W-1:0]   y;
      logic signed [15:0]          delta;
   } event_item_type;

   // One row of the hand-picked stimulus; typed rows carry their event
   typedef struct {
      logic                        touched;
      logic [tsc_pkg::RAW_W-1:0]   raw_x;
      logic [tsc_pkg::RAW_W-1:0]   raw_y;
      bit                          typed;
      tsc_pkg::event_type          ev;
      logic [tsc_pkg::POS_W-1:0]   x;
      logic [tsc_pkg::POS_W-1:0]   y;
      logic signed [15:0]          delta;
   } sample_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [tsc_pkg::POS_W-1:0] csr_wdata;

   tsc_req_if req_bus ();
   tsc_rsp_if rsp_bus ();

   touch_swipe_classifier u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Event state of the model
   logic                      m_was_touched;
   logic [tsc_pkg::POS_W-1:0] m_anchor_x, m_anchor_y;
   logic [tsc_pkg::POS_W-1:0] m_shown_x, m_shown_y;
   logic [tsc_pkg::POS_W-1:0] m_threshold;

   event_item_type pending_events[$];
   int        error_count;
   int        cycle_count;
   int        send_idle_pct;
   int        recv_idle_pct;
   bit        hold_request;
   int        hold_left;

   // Gesture generator state
   int        gest_left;
   int        gest_x, gest_y;

   sample_row_type hand_rows[19] = '{
      // idle after reset: nothing shown yet
      '{1'b0, 16'd1234, 16'd55,   1, tsc_pkg::EV_NONE,   15'd0,     15'd0,     16'sd0},
      // press with X clamped, Y at the top
      '{1'b1, 16'h8000, 16'h7FFF, 1, tsc_pkg::EV_DOWN,   15'd0,     15'd32767, 16'sd0},
      // exactly on the threshold stays held
      '{1'b1, 16'd15,   16'h7FFF, 1, tsc_pkg::EV_HELD,   15'd15,    15'd32767, 16'sd0},
      // one past the threshold moves along X
      '{1'b1, 16'd16,   16'h7FFF, 1, tsc_pkg::EV_MOVE_X, 15'd16,    15'd32767, 16'sd16},
      // full-scale drop in Y gives the largest positive delta
      '{1'b1, 16'd16,   16'd0,    1, tsc_pkg::EV_MOVE_Y, 15'd16,    15'd0,     16'sd32767},
      '{1'b1, 16'h7FFF, 16'd0,    1, tsc_pkg::EV_MOVE_X, 15'd32767, 15'd0,     16'sd32751},
      // full-scale leftward move, Y clamped
      '{1'b1, 16'd0,    16'hFFFF, 1, tsc_pkg::EV_MOVE_X, 15'd0,     15'd0,     -16'sd32767},
      // equal axes go to Y
      '{1'b1, 16'd20,   16'd20,   1, tsc_pkg::EV_MOVE_Y, 15'd20,    15'd20,    -16'sd20},
      '{1'b1, 16'd0,    16'd40,   1, tsc_pkg::EV_MOVE_Y, 15'd0,     15'd40,    -16'sd20},
      '{1'b1, 16'd0,    16'd56,   1, tsc_pkg::EV_MOVE_Y, 15'd0,     15'd56,    -16'sd16},
      '{1'b1, 16'd0,    16'd40,   1, tsc_pkg::EV_MOVE_Y, 15'd0,     15'd40,    16'sd16},
      '{1'b1, 16'd15,   16'd55,   1, tsc_pkg::EV_HELD,   15'd15,    15'd55,    16'sd0},
      // release reports this sample, Y clamped
      '{1'b0, 16'h1234, 16'hABCD, 1, tsc_pkg::EV_UP,     15'h1234,  15'd0,     16'sd0},
      // idle holds the shown position
      '{1'b0, 16'hFFFF, 16'h7FFF, 1, tsc_pkg::EV_NONE,   15'h1234,  15'd0,     16'sd0},
      '{1'b1, 16'h7FFF, 16'h7FFF, 1, tsc_pkg::EV_DOWN,   15'd32767, 15'd32767, 16'sd0},
      '{1'b0, 16'h5555, 16'h2AAA, 1, tsc_pkg::EV_UP,     15'h5555,  15'h2AAA,  16'sd0},
      '{1'b1, 16'h2AAA, 16'h5555, 1, tsc_pkg::EV_DOWN,   15'h2AAA,  15'h5555,  16'sd0},
      '{1'b1, 16'h2AB9, 16'h5546, 0, tsc_pkg::EV_NONE,   15'd0,     15'd0,     16'sd0},
      '{1'b0, 16'h8001, 16'h0001, 0, tsc_pkg::EV_NONE,   15'd0,     15'd0,     16'sd0}
   };

   // Clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Timeout
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Print one mismatch and count it
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Classify one sample and advance the model state
   function automatic event_item_type classify_sample(
         input logic touched,
         input logic [tsc_pkg::RAW_W-1:0] raw_x,
         input logic [tsc_pkg::RAW_W-1:0] raw_y);
      event_item_type            res;
      logic [tsc_pkg::POS_W-1:0] cx, cy;
      int                        dx, dy, adx, ady, th;
      cx = raw_x[tsc_pkg::RAW_W-1] ? '0 : raw_x[tsc_pkg::POS_W-1:0];
      cy = raw_y[tsc_pkg::RAW_W-1] ? '0 : raw_y[tsc_pkg::POS_W-1:0];
      res.ev    = tsc_pkg::EV_NONE;
      res.delta = '0;
      if (touched && !m_was_touched) begin
         res.ev     = tsc_pkg::EV_DOWN;
         m_shown_x  = cx;
         m_shown_y  = cy;
         m_anchor_x = cx;
         m_anchor_y = cy;
      end else if (!touched && m_was_touched) begin
         res.ev    = tsc_pkg::EV_UP;
         m_shown_x = cx;
         m_shown_y = cy;
      end else if (touched && m_was_touched) begin
         dx  = int'(cx) - int'(m_anchor_x);
         dy  = int'(cy) - int'(m_anchor_y);
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         th  = int'(m_threshold);
         res.ev    = tsc_pkg::EV_HELD;
         m_shown_x = cx;
         m_shown_y = cy;
         if (adx > th || ady > th) begin
            // dominant axis, ties to Y
            if (adx > ady) begin
               res.ev    = tsc_pkg::EV_MOVE_X;
               res.delta = 16'(dx);
            end else begin
               res.ev    = tsc_pkg::EV_MOVE_Y;
               res.delta = 16'(-dy);
            end
            m_anchor_x = cx;
            m_anchor_y = cy;
         end
      end
      m_was_touched = touched;
      res.x = m_shown_x;
      res.y = m_shown_y;
      return res;
   endfunction

   // Offer one sample and queue its event once taken; call at a rising edge
   task automatic push_sample(input logic touched,
                              input logic [tsc_pkg::RAW_W-1:0] raw_x,
                              input logic [tsc_pkg::RAW_W-1:0] raw_y,
                              input bit typed,
                              input event_item_type typed_item);
      event_item_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.touched <= touched;
      req_bus.raw_x   <= raw_x;
      req_bus.raw_y   <= raw_y;
      do @(posedge clock); while (!req_bus.ready);
      predicted = classify_sample(touched, raw_x, raw_y);
      pending_events.push_back(typed ? typed_item : predicted);
   endtask

   // Stop sending and wait until every event has come out
   task automatic drain_events();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_events.size() != 0);
   endtask

   // Write the move threshold; only while the block is empty
   task automatic write_threshold(input logic [tsc_pkg::POS_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we      <= 1'b0;
      m_threshold = value;
   endtask

   // Raw coordinate for a position, now and then with the clamp bit set
   function automatic logic [tsc_pkg::RAW_W-1:0] raw_of(input int pos);
      logic [tsc_pkg::RAW_W-1:0] raw;
      if ($urandom_range(15) == 0)
         raw = 16'h8000 | 16'($urandom_range(32767));
      else
         raw = 16'(pos);
      return raw;
   endfunction

   // Random stream: mostly gestures, some idle and noise samples
   task automatic run_random(input int count);
      event_item_type            none_item;
      logic                      touched;
      logic [tsc_pkg::RAW_W-1:0] rx, ry;
      int                        lim, step;
      none_item = '{tsc_pkg::EV_NONE, '0, '0, '0};
      for (int n = 0; n < count; n++) begin
         if (gest_left > 0) begin
            if (gest_left == 1) begin
               // release somewhere near the last position
               touched = 1'b0;
               rx      = raw_of(gest_x);
               ry      = raw_of(gest_y);
            end else begin
               lim  = int'(m_threshold) * 2 + 4;
               if (lim > POS_MAX)
                  lim = POS_MAX;
               step   = int'($urandom_range(2 * lim)) - lim;
               gest_x = gest_x + ($urandom_range(1) ? step : step / 4);
               step   = int'($urandom_range(2 * lim)) - lim;
               gest_y = gest_y + ($urandom_range(1) ? step : step / 4);
               gest_x = (gest_x < 0) ? 0 : (gest_x > POS_MAX) ? POS_MAX : gest_x;
               gest_y = (gest_y < 0) ? 0 : (gest_y > POS_MAX) ? POS_MAX : gest_y;
               touched = 1'b1;
               rx      = raw_of(gest_x);
               ry      = raw_of(gest_y);
            end
            gest_left--;
         end else if ($urandom_range(99) < 70 && !m_was_touched) begin
            // start a gesture with a press
            gest_left = $urandom_range(12, 2);
            gest_x    = $urandom_range(POS_MAX);
            gest_y    = $urandom_range(POS_MAX);
            touched   = 1'b1;
            rx        = raw_of(gest_x);
            ry        = raw_of(gest_y);
            gest_left--;
         end else begin
            // noise: any flag, any raw value
            touched = 1'($urandom_range(1));
            rx      = 16'($urandom_range(16'hFFFF));
            ry      = 16'($urandom_range(16'hFFFF));
         end
         push_sample(touched, rx, ry, 1'b0, none_item);
      end
   endtask

   // Receiver: check each event item taken, then drive ready
   initial begin
      rsp_bus.ready = 1'b0;
      hold_left     = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_events.size() == 0) begin
               report_mismatch("event item with none pending, event_res",
                               int'(rsp_bus.event_res), -1);
            end else begin
               event_item_type want;
               want = pending_events.pop_front();
               if (rsp_bus.event_res !== want.ev)
                  report_mismatch("event_res", int'(rsp_bus.event_res), int'(want.ev));
               if (rsp_bus.pos_x !== want.x)
                  report_mismatch("pos_x", int'(rsp_bus.pos_x), int'(want.x));
               if (rsp_bus.pos_y !== want.y)
                  report_mismatch("pos_y", int'(rsp_bus.pos_y), int'(want.y));
               if (rsp_bus.delta !== want.delta)
                  report_mismatch("delta", int'(rsp_bus.delta), int'(want.delta));
            end
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Main sequence
   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.touched   = 1'b0;
      req_bus.raw_x     = '0;
      req_bus.raw_y     = '0;
      error_count       = 0;
      hold_request      = 1'b0;
      gest_left         = 0;
      gest_x            = 0;
      gest_y            = 0;
      send_idle_pct     = 35;
      recv_idle_pct     = 72;
      m_was_touched     = 1'b0;
      m_anchor_x        = '0;
      m_anchor_y        = '0;
      m_shown_x         = '0;
      m_shown_y         = '0;
      m_threshold       = tsc_pkg::THRESH_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Hand-picked samples at the reset threshold
      foreach (hand_rows[i]) begin
         push_sample(hand_rows[i].touched, hand_rows[i].raw_x, hand_rows[i].raw_y,
                     hand_rows[i].typed,
                     '{hand_rows[i].ev, hand_rows[i].x, hand_rows[i].y,
                       hand_rows[i].delta});
      end

      // Sender idles lightly, receiver heavily
      run_random(150);
      hold_request = 1'b1;
      run_random(150);
      drain_events();
      write_threshold('0);
      run_random(250);
      drain_events();

      // The other way round
      send_idle_pct = 72;
      recv_idle_pct = 35;
      write_threshold(15'h7FFF);
      run_random(200);
      drain_events();
      write_threshold(15'($urandom_range(200, 1)));
      run_random(250);
      drain_events();

      // No idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_threshold(15'($urandom_range(POS_MAX)));
      run_random(150);
      drain_events();
      write_threshold(15'd7);
      run_random(100);
      hold_request = 1'b1;
      run_random(100);
      drain_events();
      run_random(100);

      drain_events();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
